@@ src/assert_macros.svh @@
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition every cycle outside reset
`define CHK_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// check that a trigger implies a condition on the next cycle
`define CHK_NEXT(label, clk, rst_n, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`endif

@@ src/pll_pkg.sv @@
// ----------------------------------------------------------------------------
// pll_pkg
// types and constants for the pooled linked list with cursor
// ----------------------------------------------------------------------------
package pll_pkg;

  localparam int PoolSlots = 64;
  localparam int DataBits  = 32;
  localparam int IdxW      = $clog2(PoolSlots);
  localparam int LinkW     = IdxW + 1;
  localparam logic [LinkW-1:0] NIL = LinkW'(PoolSlots);

  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_START  = 3'd3;
  localparam logic [2:0] REQ_STEP   = 3'd4;
  localparam logic [2:0] REQ_INDEX  = 3'd5;
  localparam logic [2:0] REQ_END    = 3'd6;
  localparam logic [2:0] REQ_CLEAR  = 3'd7;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_END   = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] value;
    logic [6:0]  position;
  } pll_in_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [6:0]  element_count;
    logic        at_begin;
    logic        at_end;
    logic        is_full;
  } pll_out_t;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,  // rd = link of cursor
    OP_LOAD  = 4'd1,  // capture request, rd = link of cursor
    OP_RDCUR = 4'd2,  // cur = link, rd = link of cur
    OP_PLACE = 4'd3,  // as rdcur, and fill the lowest free slot
    OP_INS   = 4'd4,  // link the new slot after the cursor
    OP_REM   = 4'd5,  // unlink cur, keep its data
    OP_READ  = 4'd6,  // keep data of cur
    OP_HOME  = 4'd7,  // cursor to head marker
    OP_STEP  = 4'd8,  // cursor = cur
    OP_IDX0  = 4'd9,  // cursor to head marker, walk = head, rd = link of head
    OP_END0  = 4'd10, // walk = cur, rd = link of cur
    OP_WALK  = 4'd11, // cursor = walk, walk = link, rd = link of walk
    OP_POST2 = 4'd12, // walk = link of cursor, rd = link of walk
    OP_CLR   = 4'd13
  } pll_op_t;

  typedef struct packed {
    logic       cur_nil;
    logic       nxt_nil;
    logic       walk_done;
    logic       full;
    logic [2:0] req;
    logic       pos_ok;
  } pll_stat_t;

endpackage

@@ src/pll_dp.sv @@
// ----------------------------------------------------------------------------
// pll_dp
// slot memories, list registers and result formation
// ----------------------------------------------------------------------------
module pll_dp import pll_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  pll_in_t   in_req,
  input  pll_op_t   op,
  input  logic [1:0] st_code,
  output pll_stat_t stat,
  output pll_out_t  res
);

  logic [DataBits-1:0] mem_data [PoolSlots];
  logic [LinkW-1:0]    mem_next [PoolSlots];
  logic [PoolSlots-1:0] used_r;

  logic [LinkW-1:0] head_r, cursor_r, cur_r, walk_r;
  logic [6:0] count_r, steps_r, pos_r;
  logic [2:0] req_r;
  logic [DataBits-1:0] val_r, rdata_r, dout_r;
  logic [IdxW-1:0] free_idx;

  logic [LinkW-1:0] rd_idx;
  logic [LinkW-1:0] link_rd;
  logic             rd_head;
  logic [LinkW-1:0] link_val;
  logic             next_we;
  logic [IdxW-1:0]  next_wa;
  logic [LinkW-1:0] next_wd;

  // link of the last read position, head marker reads head register
  assign link_val = rd_head ? head_r : link_rd;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = PoolSlots - 1; i >= 0; i--) begin
      if (!used_r[i]) free_idx = IdxW'(i);
    end
  end

  // read address select
  always_comb begin
    rd_idx = cursor_r;
    if (op == OP_RDCUR || op == OP_PLACE || op == OP_WALK || op == OP_POST2) begin
      rd_idx = link_val;
    end else if (op == OP_IDX0) begin
      rd_idx = head_r;
    end else if (op == OP_END0) begin
      rd_idx = cur_r;
    end
  end

  // single write port for the link memory
  always_comb begin
    next_we = 1'b0;
    next_wa = free_idx;
    next_wd = link_val;
    if (op == OP_PLACE) begin
      next_we = 1'b1;
    end else if (op == OP_INS && !cursor_r[IdxW]) begin
      next_we = 1'b1;
      next_wa = cursor_r[IdxW-1:0];
      next_wd = {1'b0, free_idx};
    end else if (op == OP_REM && !cursor_r[IdxW]) begin
      next_we = 1'b1;
      next_wa = cursor_r[IdxW-1:0];
      next_wd = link_val;
    end
  end

  // registered memory reads and writes
  always_ff @(posedge clk) begin
    rd_head <= rd_idx[IdxW];
    link_rd <= mem_next[rd_idx[IdxW-1:0]];
    rdata_r <= mem_data[rd_idx[IdxW-1:0]];
    if (op == OP_PLACE) mem_data[free_idx] <= val_r;
    if (next_we) mem_next[next_wa] <= next_wd;
  end

  // list registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r   <= '0;
      head_r   <= NIL;
      cursor_r <= NIL;
      count_r  <= '0;
    end else begin
      case (op)
        OP_INS: begin
          used_r[free_idx] <= 1'b1;
          if (cursor_r[IdxW]) head_r <= {1'b0, free_idx};
          count_r <= count_r + 7'd1;
        end
        OP_REM: begin
          used_r[cur_r[IdxW-1:0]] <= 1'b0;
          if (cursor_r[IdxW]) head_r <= link_val;
          count_r <= count_r - 7'd1;
        end
        OP_HOME:  cursor_r <= NIL;
        OP_STEP:  cursor_r <= cur_r;
        OP_IDX0:  cursor_r <= NIL;
        OP_WALK:  cursor_r <= walk_r;
        OP_CLR: begin
          used_r   <= '0;
          head_r   <= NIL;
          cursor_r <= NIL;
          count_r  <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        req_r  <= in_req.req_type;
        val_r  <= in_req.value;
        pos_r  <= in_req.position;
        dout_r <= '0;
      end
      OP_RDCUR: cur_r <= link_val;
      OP_PLACE: cur_r <= link_val;
      OP_REM:   dout_r <= rdata_r;
      OP_READ:  dout_r <= rdata_r;
      OP_IDX0: begin
        walk_r  <= head_r;
        steps_r <= '0;
      end
      OP_END0:  walk_r <= cur_r;
      OP_WALK: begin
        walk_r  <= link_val;
        steps_r <= steps_r + 7'd1;
      end
      OP_POST2: walk_r <= link_val;
      default: ;
    endcase
  end

  assign stat.cur_nil   = cur_r[IdxW];
  assign stat.nxt_nil   = link_val[IdxW];
  assign stat.walk_done = (req_r == REQ_INDEX) ? (steps_r == pos_r || walk_r[IdxW])
                                               : (walk_r[IdxW] || link_val[IdxW]);
  assign stat.full      = (count_r >= 7'(PoolSlots));
  assign stat.req       = req_r;
  assign stat.pos_ok    = (pos_r < count_r);

  // result fields
  always_comb begin
    res.data_out      = dout_r;
    res.status        = st_code;
    res.element_count = count_r;
    res.at_begin      = cursor_r[IdxW];
    res.at_end        = walk_r[IdxW] || link_val[IdxW];
    res.is_full       = (count_r >= 7'(PoolSlots));
  end

endmodule

@@ src/pll_ctrl.sv @@
// ----------------------------------------------------------------------------
// pll_ctrl
// sequencer for list requests
// ----------------------------------------------------------------------------
module pll_ctrl import pll_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  pll_stat_t stat,
  output pll_op_t   op,
  output logic [1:0] st_code,
  output logic      done
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CUR   = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_WALK  = 7'b0001000,
    S_POST  = 7'b0010000,
    S_AHEAD = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] st_r, st_nxt;

  assign busy = (state_r != S_IDLE);
  assign st_code = st_r;

  always_comb begin
    state_nxt = state_r;
    st_nxt = st_r;
    op = OP_NONE;
    done = 1'b0;
    unique case (state_r)
      S_IDLE: if (start) begin
        op = OP_LOAD;
        st_nxt = ST_OK;
        state_nxt = S_CUR;
      end
      // fetch current element, place new data early for insert
      S_CUR: begin
        op = (stat.req == REQ_INSERT && !stat.full) ? OP_PLACE : OP_RDCUR;
        state_nxt = S_EXEC;
      end
      // execute the request
      S_EXEC: begin
        state_nxt = S_POST;
        unique case (stat.req)
          REQ_INSERT: if (stat.full) st_nxt = ST_FULL; else op = OP_INS;
          REQ_REMOVE: if (stat.cur_nil) st_nxt = ST_UNDER; else op = OP_REM;
          REQ_READ:   if (stat.cur_nil) st_nxt = ST_UNDER; else op = OP_READ;
          REQ_START:  op = OP_HOME;
          REQ_STEP: begin
            if (stat.cur_nil || stat.nxt_nil) st_nxt = ST_END;
            else op = OP_STEP;
          end
          REQ_INDEX: begin
            if (stat.pos_ok) begin
              op = OP_IDX0;
              state_nxt = S_WALK;
            end else begin
              st_nxt = ST_END;
            end
          end
          REQ_END: if (!stat.cur_nil) begin
            op = OP_END0;
            state_nxt = S_WALK;
          end
          REQ_CLEAR:  op = OP_CLR;
        endcase
      end
      // one link per cycle
      S_WALK: begin
        if (stat.walk_done) state_nxt = S_POST;
        else op = OP_WALK;
      end
      // look two links ahead of the cursor for the end flag
      S_POST: state_nxt = S_AHEAD;
      S_AHEAD: begin
        op = OP_POST2;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r <= st_nxt;
    end
  end

endmodule

@@ src/pooled_linked_list_with_cursor.sv @@
// ----------------------------------------------------------------------------
// pooled_linked_list_with_cursor
// linked list in a 64-slot pool with a cursor, one result per request
// ----------------------------------------------------------------------------
// channel  ports                  handshake
// request  in_req                 start & !busy
// result   out_res                out_valid, one cycle
// sequence: a taken request passes the states cur, exec, post, ahead and fin;
//   busy through fin, which raises the result strobe, next request taken in idle
// walks: an index in range and an end with a current element step the list
//   link by link in the walk state before post
// reset: synchronous, list empty, cursor at head
// stalls: the receiver cannot stall
module pooled_linked_list_with_cursor import pll_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  pll_in_t  in_req,
  output logic     out_valid,
  output pll_out_t out_res
);
`include "assert_macros.svh"

  pll_op_t    op;
  pll_stat_t  stat;
  logic [1:0] st_code;
  logic       done;

  pll_ctrl u_ctrl (.clk, .rst_n, .start, .busy, .stat, .op, .st_code, .done);
  pll_dp   u_dp   (.clk, .rst_n, .in_req, .op, .st_code, .stat, .res(out_res));

  assign out_valid = done;

  `CHK_ALWAYS(a_cnt, clk, rst_n, out_res.element_count <= 7'(PoolSlots), "count overflow")
  `CHK_NEXT(a_busy, clk, rst_n, start && !busy, busy, "request not taken")
  `CHK_NEXT(a_free, clk, rst_n, out_valid, !busy, "busy after result")

endmodule

@@ test/tb_pooled_linked_list_with_cursor.sv @@
// ----------------------------------------------------------------------------
// tb_pooled_linked_list_with_cursor
// drives list requests through the command port and checks every result
// against a behavioral model of the pooled list with cursor
// ----------------------------------------------------------------------------
module tb_pooled_linked_list_with_cursor;
  import pll_pkg::*;

  localparam int WatchLimit = 20000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  pll_in_t  in_req;
  logic     out_valid;
  pll_out_t out_res;

  pooled_linked_list_with_cursor DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  // list model state
  logic [31:0]      mdl_data [PoolSlots];
  logic [LinkW-1:0] mdl_next [PoolSlots];
  logic             mdl_used [PoolSlots];
  logic [LinkW-1:0] mdl_head;
  logic [LinkW-1:0] mdl_cursor;
  int               mdl_count;

  pll_in_t  pending_reqs [$];
  pll_out_t expected_results [$];
  int  n_errors = 0;
  int  idle_left = 0;
  bit  idle_on = 1;
  bit  hold_drain = 0;
  bit  stim_done = 0;
  bit  taken = 0;
  int  watch = 0;

  initial clk = 0;
  always #5 clk = ~clk;

  function automatic logic [LinkW-1:0] link_from(logic [LinkW-1:0] pos);
    logic [LinkW-1:0] n;
    n = (pos >= NIL) ? mdl_head : mdl_next[pos[IdxW-1:0]];
    return (n < NIL) ? n : NIL;
  endfunction

  function automatic bit cursor_last();
    logic [LinkW-1:0] c;
    c = link_from(mdl_cursor);
    return (c == NIL) || (link_from(c) == NIL);
  endfunction

  function automatic void list_reset();
    for (int i = 0; i < PoolSlots; i++) mdl_used[i] = 0;
    mdl_head = NIL;
    mdl_cursor = NIL;
    mdl_count = 0;
  endfunction

  // apply one request to the list model and return its result
  function automatic pll_out_t list_apply(pll_in_t r);
    pll_out_t o;
    logic [LinkW-1:0] c;
    int slot;
    o = '0;
    o.status = ST_OK;
    c = link_from(mdl_cursor);
    case (r.req_type)
      REQ_INSERT: begin
        slot = -1;
        for (int i = 0; i < PoolSlots; i++)
          if (slot < 0 && !mdl_used[i]) slot = i;
        if (mdl_count >= PoolSlots || slot < 0) begin
          o.status = ST_FULL;
        end else begin
          mdl_data[slot] = r.value;
          mdl_used[slot] = 1;
          mdl_next[slot] = c;
          if (mdl_cursor >= NIL) mdl_head = LinkW'(slot);
          else mdl_next[mdl_cursor[IdxW-1:0]] = LinkW'(slot);
          mdl_count++;
        end
      end
      REQ_REMOVE, REQ_READ: begin
        if (c == NIL) begin
          o.status = ST_UNDER;
        end else begin
          o.data_out = mdl_data[c[IdxW-1:0]];
          if (r.req_type == REQ_REMOVE) begin
            mdl_used[c[IdxW-1:0]] = 0;
            if (mdl_cursor >= NIL) mdl_head = link_from(c);
            else mdl_next[mdl_cursor[IdxW-1:0]] = link_from(c);
            if (mdl_count > 0) mdl_count--;
          end
        end
      end
      REQ_START: mdl_cursor = NIL;
      REQ_STEP: begin
        if (cursor_last()) o.status = ST_END;
        else mdl_cursor = c;
      end
      REQ_INDEX: begin
        if (r.position < mdl_count) begin
          mdl_cursor = NIL;
          for (int i = 0; i < r.position; i++)
            if (link_from(mdl_cursor) != NIL) mdl_cursor = link_from(mdl_cursor);
        end else begin
          o.status = ST_END;
        end
      end
      REQ_END: begin
        for (int i = 0; i < PoolSlots && !cursor_last(); i++)
          mdl_cursor = link_from(mdl_cursor);
      end
      default: list_reset();
    endcase
    o.element_count = 7'(mdl_count);
    o.at_begin = (mdl_cursor >= NIL);
    o.at_end = cursor_last();
    o.is_full = (mdl_count >= PoolSlots);
    return o;
  endfunction

  function automatic pll_in_t mk_req(logic [2:0] t, logic [31:0] v, logic [6:0] p);
    pll_in_t r;
    r.req_type = t;
    r.value = v;
    r.position = p;
    return r;
  endfunction

  // driver: one request per handshake, random idle bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 0;
      taken = 0;
    end else if (start && !taken) begin
      // hold the request until accepted
    end else begin
      taken = 0;
      if (pending_reqs.size() == 0 || (hold_drain && expected_results.size() != 0)) begin
        start <= 0;
      end else if (idle_left > 0) begin
        idle_left <= idle_left - 1;
        start <= 0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        idle_left <= $urandom_range(1, 15);
        start <= 0;
      end else begin
        in_req <= pending_reqs.pop_front();
        start <= 1;
      end
    end
  end

  // request acceptance feeds the model, result port is checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        expected_results.push_back(list_apply(in_req));
        taken = 1;
        watch <= 0;
      end else if (out_valid) begin
        watch <= 0;
      end else begin
        watch <= watch + 1;
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result %p", out_res);
          n_errors++;
        end else begin
          pll_out_t e;
          e = expected_results.pop_front();
          if (e.data_out !== out_res.data_out) begin
            $error("data_out exp %h got %h", e.data_out, out_res.data_out); n_errors++;
          end
          if (e.status !== out_res.status) begin
            $error("status exp %0d got %0d", e.status, out_res.status); n_errors++;
          end
          if (e.element_count !== out_res.element_count) begin
            $error("element_count exp %0d got %0d", e.element_count,
                   out_res.element_count); n_errors++;
          end
          if (e.at_begin !== out_res.at_begin) begin
            $error("at_begin exp %b got %b", e.at_begin, out_res.at_begin); n_errors++;
          end
          if (e.at_end !== out_res.at_end) begin
            $error("at_end exp %b got %b", e.at_end, out_res.at_end); n_errors++;
          end
          if (e.is_full !== out_res.is_full) begin
            $error("is_full exp %b got %b", e.is_full, out_res.is_full); n_errors++;
          end
        end
      end
    end
  end

  // random request, mostly well-formed list traffic
  function automatic pll_in_t rand_req(int fill_bias);
    int k;
    logic [31:0] v;
    k = $urandom_range(0, 99);
    v = $urandom();
    if (k < fill_bias) return mk_req(REQ_INSERT, v, 7'($urandom()));
    if (k < 55) return mk_req(REQ_REMOVE, v, 7'($urandom()));
    if (k < 65) return mk_req(REQ_READ, v, 7'($urandom()));
    if (k < 72) return mk_req(REQ_START, v, 7'($urandom()));
    if (k < 82) return mk_req(REQ_STEP, v, 7'($urandom()));
    if (k < 92) return mk_req(REQ_INDEX, v, 7'($urandom_range(0, 70)));
    if (k < 97) return mk_req(REQ_END, v, 7'($urandom()));
    return mk_req(REQ_CLEAR, v, 7'($urandom()));
  endfunction

  initial begin
    rst_n = 0;
    start = 0;
    in_req = '0;
    list_reset();
    // directed: empty-list corners, extremes, every request type
    pending_reqs.push_back(mk_req(REQ_REMOVE, 32'hFFFFFFFF, 7'h7F));
    pending_reqs.push_back(mk_req(REQ_READ, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_STEP, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_END, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_INDEX, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_INSERT, 32'h0, 7'h7F));
    pending_reqs.push_back(mk_req(REQ_INSERT, 32'hFFFFFFFF, 7'h0));
    pending_reqs.push_back(mk_req(REQ_INSERT, 32'hA5A5_5A5A, 7'h0));
    pending_reqs.push_back(mk_req(REQ_READ, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_STEP, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_STEP, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_STEP, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_INDEX, 32'h0, 7'd2));
    pending_reqs.push_back(mk_req(REQ_INDEX, 32'h0, 7'd3));
    pending_reqs.push_back(mk_req(REQ_INDEX, 32'h0, 7'd64));
    pending_reqs.push_back(mk_req(REQ_START, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_REMOVE, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_END, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_REMOVE, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_CLEAR, 32'h0, 7'h0));
    // fill the pool to full and overflow it
    for (int i = 0; i < 66; i++) pending_reqs.push_back(mk_req(REQ_INSERT, $urandom(), 7'h0));
    pending_reqs.push_back(mk_req(REQ_INDEX, 32'h0, 7'd63));
    pending_reqs.push_back(mk_req(REQ_END, 32'h0, 7'h0));
    pending_reqs.push_back(mk_req(REQ_REMOVE, 32'h0, 7'h0));
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1;
    // random part, phases with grow and shrink bias
    for (int ph = 0; ph < 4; ph++) begin
      for (int i = 0; i < 135; i++) pending_reqs.push_back(rand_req(ph[0] ? 60 : 35));
      if (ph == 1) begin
        wait (pending_reqs.size() == 0);
        hold_drain = 1;
        for (int i = 0; i < 20; i++) pending_reqs.push_back(rand_req(45));
        wait (expected_results.size() == 0);
        @(posedge clk);
        hold_drain = 0;
      end
      if (ph == 3) idle_on = 0;
    end
    stim_done = 1;
  end

  // end of run and watchdog
  initial begin
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (watch >= WatchLimit) begin
        $display("tb_pooled_linked_list_with_cursor: FAIL");
        $finish;
      end
      if (stim_done && pending_reqs.size() == 0 && expected_results.size() == 0
          && !start) begin
        repeat (200) @(posedge clk);
        if (n_errors == 0 && expected_results.size() == 0)
          $display("tb_pooled_linked_list_with_cursor: PASS");
        else
          $display("tb_pooled_linked_list_with_cursor: FAIL");
        $finish;
      end
    end
  end

endmodule
